/* hdl/sts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and constants of the sine series block.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int MAX_TERMS = 64;
    localparam int FRAC_BITS = 24;

    localparam int ANGLE_W = 32;
    localparam int RED_W   = 28;
    localparam int AX_W    = 27;
    localparam int MAG_W   = 31;
    localparam int SUM_W   = 32;
    localparam int CNT_W   = $clog2(MAX_TERMS + 1);
    localparam int IDX_W   = $clog2(MAX_TERMS);
    localparam int RECIP_W = 30;
    localparam int PROD_W  = MAG_W + RECIP_W;

    localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
    localparam logic [63:0] TWO_PI_RND =
        (TWO_PI_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
    localparam logic [AX_W-1:0] TWO_PI = TWO_PI_RND[AX_W-1:0];

    localparam int  RED_STEPS = 5;
    localparam int  STEP_W    = 3;
    localparam int  REM_W     = 32;

    localparam int          DATA_W      = 32;
    localparam int          ADDR_W      = 3;
    localparam logic        REG_EPSILON = 1'b0;
    localparam logic [MAG_W-1:0] EPSILON_RST = 31'd17;

    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic signed [RED_W-1:0] x;
        logic        [AX_W-1:0]  ax;
    } t_item;

endpackage

/* hdl/sts_reduce.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_reduce
// Front end: takes an angle and reduces it modulo two pi, one step a cycle.
// ----------------------------------------------------------------------------
module sts_reduce (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  logic signed [sts_pkg::ANGLE_W-1:0]  i_angle,
    output logic                                o_full,
    output logic                                o_push,
    output sts_pkg::t_item                      o_item,
    input  logic                                i_q_full
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_REDUCE,
        S_SEND
    } t_state;

    t_state                          r_state;
    logic [sts_pkg::REM_W-1:0]       r_rem;
    logic                            r_neg;
    logic                            r_big;
    logic [sts_pkg::STEP_W-1:0]      r_step;

    logic signed [sts_pkg::ANGLE_W:0] w_ext;
    logic        [sts_pkg::ANGLE_W:0] w_abs;
    logic        [sts_pkg::REM_W-1:0] w_div;
    logic        [sts_pkg::AX_W-1:0]  w_mag;
    logic signed [sts_pkg::RED_W-1:0] w_x;
    logic                             w_flip;

    assign w_ext = {i_angle[sts_pkg::ANGLE_W-1], i_angle};
    assign w_abs = w_ext[sts_pkg::ANGLE_W] ? unsigned'(-w_ext) : unsigned'(w_ext);
    assign w_div = sts_pkg::REM_W'(sts_pkg::TWO_PI) << r_step;

    assign w_flip = r_big && r_neg && (r_rem != '0);
    assign w_mag  = w_flip ? sts_pkg::TWO_PI - r_rem[sts_pkg::AX_W-1:0]
                           : r_rem[sts_pkg::AX_W-1:0];

    assign w_x    = (!r_big && r_neg) ? -signed'({1'b0, w_mag})
                                      : signed'({1'b0, w_mag});

    assign o_full = (r_state != S_IDLE);
    assign o_push = (r_state == S_SEND) && !i_q_full;
    assign o_item = '{x: w_x, ax: w_mag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_push) begin
                        r_rem   <= w_abs[sts_pkg::REM_W-1:0];
                        r_neg   <= i_angle[sts_pkg::ANGLE_W-1];
                        r_big   <= (w_abs >= (sts_pkg::ANGLE_W+1)'(sts_pkg::TWO_PI));
                        r_step  <= sts_pkg::STEP_W'(sts_pkg::RED_STEPS - 1);
                        r_state <= S_REDUCE;
                    end
                end
                S_REDUCE: begin
                    if (r_rem >= w_div) begin
                        r_rem <= r_rem - w_div;
                    end
                    if (r_step == '0) begin
                        r_state <= S_SEND;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                S_SEND: begin
                    if (!i_q_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* hdl/sts_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_queue
// Short queue of reduced angles between the front end and the series engine.
// ----------------------------------------------------------------------------
module sts_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sts_pkg::t_item  i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output sts_pkg::t_item  o_item
);

    localparam int PTR_W = $clog2(sts_pkg::Q_DEPTH);
    localparam int CNT_W = $clog2(sts_pkg::Q_DEPTH + 1);

    sts_pkg::t_item    r_mem [sts_pkg::Q_DEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [CNT_W-1:0]  r_cnt;

    logic w_wr;
    logic w_rd;

    assign o_full  = (r_cnt == CNT_W'(sts_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == PTR_W'(sts_pkg::Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= (r_rp == PTR_W'(sts_pkg::Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* hdl/sts_series.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_series
// Back end: sums the sine series on one shared multiplier, through the check,
// mul1, mul2 and mul3 states for each term, and holds the finished result in an output register.
// ----------------------------------------------------------------------------
module sts_series (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [sts_pkg::MAG_W-1:0]           i_epsilon,
    input  logic                                i_q_valid,
    input  sts_pkg::t_item                      i_item,
    output logic                                o_q_pop,
    input  logic                                i_pop,
    output logic                                o_empty,
    output logic signed [sts_pkg::RED_W-1:0]    o_reduced_angle,
    output logic signed [sts_pkg::SUM_W-1:0]    o_series_sum,
    output logic [sts_pkg::MAG_W-1:0]           o_last_term_size,
    output logic [6:0]                          o_terms_used,
    output logic                                o_limit_hit
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_FINISH
    } t_state;

    localparam int PW = sts_pkg::PROD_W;
    localparam int FB = sts_pkg::FRAC_BITS;

    function automatic logic [sts_pkg::MAG_W-1:0] round_sat(input logic [PW-1:0] v);
        logic [PW:0] s;
        s = {1'b0, v} + ((PW+1)'(1) << (FB - 1));
        if (s[PW:FB+sts_pkg::MAG_W] != '0) begin
            return '1;
        end
        return s[FB+sts_pkg::MAG_W-1:FB];
    endfunction

    logic [sts_pkg::RECIP_W-1:0] w_recip [sts_pkg::MAX_TERMS];

    for (genvar k = 0; k < sts_pkg::MAX_TERMS; k++) begin : g_recip
        localparam longint unsigned DIV = (2 * k + 2) * (2 * k + 3);
        localparam longint unsigned RV  = ((64'd1 << 32) + DIV / 2) / DIV;
        assign w_recip[k] = RV[sts_pkg::RECIP_W-1:0];
    end

    t_state                              r_state;
    logic signed [sts_pkg::RED_W-1:0]    r_x;
    logic [sts_pkg::AX_W-1:0]            r_ax;
    logic [sts_pkg::MAG_W-1:0]           r_mag;
    logic                                r_neg;
    logic signed [sts_pkg::SUM_W-1:0]    r_sum;
    logic [sts_pkg::MAG_W-1:0]           r_last;
    logic [sts_pkg::CNT_W-1:0]           r_cnt;
    logic [PW-1:0]                       r_prod;
    logic                                r_out_valid;

    logic [sts_pkg::MAG_W-1:0]           w_mul_a;
    logic [sts_pkg::RECIP_W-1:0]         w_mul_b;
    logic [PW-1:0]                       w_prod;
    logic [PW:0]                         w_div_rnd;
    logic signed [sts_pkg::SUM_W:0]      w_term;
    logic signed [sts_pkg::SUM_W:0]      w_acc;
    logic signed [sts_pkg::SUM_W-1:0]    w_sum_sat;
    logic                                w_go;
    logic                                w_slot_free;

    always_comb begin
        case (r_state)
            S_MUL1: begin
                w_mul_a = round_sat(r_prod);
                w_mul_b = sts_pkg::RECIP_W'(r_ax);
            end
            S_MUL2: begin
                w_mul_a = round_sat(r_prod);
                w_mul_b = w_recip[r_cnt[sts_pkg::IDX_W-1:0]];
            end
            default: begin
                w_mul_a = r_mag;
                w_mul_b = sts_pkg::RECIP_W'(r_ax);
            end
        endcase
    end

    assign w_prod    = w_mul_a * w_mul_b;
    assign w_div_rnd = {1'b0, r_prod} + ((PW+1)'(1) << 31);

    assign w_term = r_neg ? -signed'({2'b00, r_mag}) : signed'({2'b00, r_mag});
    assign w_acc  = {r_sum[sts_pkg::SUM_W-1], r_sum} + w_term;

    always_comb begin
        if (w_acc[sts_pkg::SUM_W] != w_acc[sts_pkg::SUM_W-1]) begin
            w_sum_sat = w_acc[sts_pkg::SUM_W] ? {1'b1, {(sts_pkg::SUM_W-1){1'b0}}}
                                              : {1'b0, {(sts_pkg::SUM_W-1){1'b1}}};
        end else begin
            w_sum_sat = w_acc[sts_pkg::SUM_W-1:0];
        end
    end

    assign w_go        = (r_cnt < sts_pkg::CNT_W'(sts_pkg::MAX_TERMS)) && (r_mag >= i_epsilon);
    assign w_slot_free = !r_out_valid || i_pop;
    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid;
    assign o_empty     = !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_FINISH) && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_x     <= i_item.x;
                        r_ax    <= i_item.ax;
                        r_mag   <= sts_pkg::MAG_W'(i_item.ax);
                        r_neg   <= i_item.x[sts_pkg::RED_W-1];
                        r_sum   <= '0;
                        r_last  <= '0;
                        r_cnt   <= '0;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (w_go) begin
                        r_sum   <= w_sum_sat;
                        r_last  <= r_mag;
                        r_prod  <= w_prod;
                        r_state <= S_MUL1;
                    end else begin
                        r_state <= S_FINISH;
                    end
                end
                S_MUL1: begin
                    r_prod  <= w_prod;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_prod  <= w_prod;
                    r_state <= S_MUL3;
                end
                S_MUL3: begin
                    r_mag   <= {1'b0, w_div_rnd[PW:32]};
                    r_neg   <= !r_neg;
                    r_cnt   <= r_cnt + 1'b1;
                    r_state <= S_CHECK;
                end
                S_FINISH: begin
                    if (w_slot_free) begin
                        o_reduced_angle  <= r_x;
                        o_series_sum     <= r_sum;
                        o_last_term_size <= r_last;
                        o_terms_used     <= 7'(r_cnt);
                        o_limit_hit      <= (r_mag >= i_epsilon);
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* hdl/sine_taylor_series.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_taylor_series
// Fixed-point sine by its Maclaurin series, with angle reduction modulo 2*pi.
// ----------------------------------------------------------------------------
// Input channel: drive i_angle (signed Q8.24) with push; the transaction
// completes when push is high and full is low. Result channel: while empty is
// low the result ports hold the oldest result; pop takes it.
// The front end reduces the angle in 5 restoring steps on 2*pi multiples. A
// two-entry queue then feeds the series engine, which uses one shared
// multiplier three times a term; each added term passes the check, mul1, mul2
// and mul3 states, and each item also takes a load, a final check and a
// writeback. The front end reduces the next angle while the engine works.
// The engine stops when the result register is occupied and pop is low; the
// queue then fills and full rises. Epsilon is written over the APB port
// (address 0); the user must write it only while the block is idle, and the
// block itself does not enforce this. Reset (synchronous, active low) empties
// the queue and the result register and sets epsilon to 17.
// ----------------------------------------------------------------------------
module sine_taylor_series (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [sts_pkg::ANGLE_W-1:0]  i_angle,
    input  logic                                pop,
    output logic                                empty,
    output logic signed [sts_pkg::RED_W-1:0]    o_reduced_angle,
    output logic signed [sts_pkg::SUM_W-1:0]    o_series_sum,
    output logic [sts_pkg::MAG_W-1:0]           o_last_term_size,
    output logic [6:0]                          o_terms_used,
    output logic                                o_limit_hit,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sts_pkg::ADDR_W-1:0]          paddr,
    input  logic [sts_pkg::DATA_W-1:0]          pwdata,
    output logic [sts_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);

    logic [sts_pkg::MAG_W-1:0] r_epsilon;

    logic            w_fe_push;
    sts_pkg::t_item  w_fe_item;
    logic            w_q_full;
    logic            w_q_valid;
    logic            w_q_pop;
    sts_pkg::t_item  w_q_item;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == sts_pkg::REG_EPSILON) ? {1'b0, r_epsilon} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epsilon <= sts_pkg::EPSILON_RST;
        end else if (psel && penable && pwrite && (paddr[2] == sts_pkg::REG_EPSILON)) begin
            r_epsilon <= pwdata[sts_pkg::MAG_W-1:0];
        end
    end

    sts_reduce u_reduce (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_angle  (i_angle),
        .o_full   (full),
        .o_push   (w_fe_push),
        .o_item   (w_fe_item),
        .i_q_full (w_q_full)
    );

    sts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fe_push),
        .i_item  (w_fe_item),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    sts_series u_series (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_epsilon        (r_epsilon),
        .i_q_valid        (w_q_valid),
        .i_item           (w_q_item),
        .o_q_pop          (w_q_pop),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_reduced_angle  (o_reduced_angle),
        .o_series_sum     (o_series_sum),
        .o_last_term_size (o_last_term_size),
        .o_terms_used     (o_terms_used),
        .o_limit_hit      (o_limit_hit)
    );

endmodule

/* hdl/sts_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_checker
// Port-level checks of the sine series block, bound to the top level.
// ----------------------------------------------------------------------------
module sts_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                pop,
    input  logic                                empty,
    input  logic signed [sts_pkg::RED_W-1:0]    o_reduced_angle,
    input  logic signed [sts_pkg::SUM_W-1:0]    o_series_sum,
    input  logic [sts_pkg::MAG_W-1:0]           o_last_term_size,
    input  logic [6:0]                          o_terms_used,
    input  logic                                o_limit_hit
);

    localparam logic signed [sts_pkg::RED_W-1:0] TP =
        signed'({1'b0, sts_pkg::TWO_PI});

    a_limit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_limit_hit) |-> (o_terms_used == 7'(sts_pkg::MAX_TERMS)))
        else $error("limit flag without full term count");

    a_no_terms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_terms_used == 7'd0)) |->
            ((o_series_sum == '0) && (o_last_term_size == '0) && !o_limit_hit))
        else $error("nonzero sum with no terms");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_reduced_angle < TP) && (o_reduced_angle > -TP)))
        else $error("reduced angle out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_series_sum) && $stable(o_terms_used)))
        else $error("result changed while stalled");

endmodule

bind sine_taylor_series sts_checker u_sts_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .pop              (pop),
    .empty            (empty),
    .o_reduced_angle  (o_reduced_angle),
    .o_series_sum     (o_series_sum),
    .o_last_term_size (o_last_term_size),
    .o_terms_used     (o_terms_used),
    .o_limit_hit      (o_limit_hit)
);
